@@ src/rgb_led_frame_encoder_assert.svh @@
// Assertion macros for the LED frame encoder.
// No dependencies; included by the top level.
`ifndef RGB_LED_FRAME_ENCODER_ASSERT_SVH
`define RGB_LED_FRAME_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RGBE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define RGBE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define RGBE_ASSERT_IMP(label, clk, rst, ante, cons)
`define RGBE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/rgbe_pkg.sv @@
// Shared types, codes and color tables for the LED frame encoder.
// No dependencies.
package rgbe_pkg;

  // input actions
  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // register indexes (address bit 2)
  localparam logic REG_ZERO_CMP = 1'b0;
  localparam logic REG_ONE_CMP  = 1'b1;

  localparam logic [7:0] ZERO_CMP_RESET = 8'd23;
  localparam logic [7:0] ONE_CMP_RESET  = 8'd46;

  localparam int unsigned BITS_PER_LED = 24;
  localparam logic [6:0]  PCT_MAX      = 7'd100;

  // floor(x/100) == (x*5243)>>19 for x < 25600
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  // write request from the scaler to the bit store
  typedef struct packed {
    logic        en;
    logic [1:0]  led;
    logic [23:0] grb;
  } rgbe_wr_t;

  function automatic logic [7:0] tbl_green(input logic [2:0] code);
    logic [7:0] v;
    unique case (code)
      3'd1:    v = 8'd150;
      3'd4:    v = 8'd100;
      3'd6:    v = 8'd200;
      3'd7:    v = 8'd150;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] tbl_red(input logic [2:0] code);
    logic [7:0] v;
    unique case (code)
      3'd2:    v = 8'd255;
      3'd5:    v = 8'd255;
      3'd6:    v = 8'd150;
      3'd7:    v = 8'd150;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] tbl_blue(input logic [2:0] code);
    logic [7:0] v;
    unique case (code)
      3'd3:    v = 8'd255;
      3'd4:    v = 8'd255;
      3'd5:    v = 8'd255;
      3'd7:    v = 8'd150;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/rgbe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgbe_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/rgbe_scale.sv @@
// Color scaler: table lookup, brightness multiply, divide by 100 via reciprocal.
// Depends on rgbe_pkg.
module rgbe_scale
  import rgbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] led_index,
  input  logic [2:0] color_code,
  input  logic [6:0] brightness,
  output rgbe_wr_t   wr,
  output logic       busy
);

  logic        s1_v;
  logic [1:0]  s1_led;
  logic [14:0] s1_prod [3];
  logic        s2_v;
  logic [1:0]  s2_led;
  logic [7:0]  s2_q [3];

  logic [6:0]  pct;
  logic [7:0]  lvl [3];
  logic [27:0] scaled [3];

  // saturate brightness, look up channel levels (G, R, B)
  always_comb begin
    pct    = (brightness > PCT_MAX) ? PCT_MAX : brightness;
    lvl[0] = tbl_green(color_code);
    lvl[1] = tbl_red(color_code);
    lvl[2] = tbl_blue(color_code);
  end

  // reciprocal multiply of the registered products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scaled[i] = {13'b0, s1_prod[i]} * {15'b0, RECIP_100};
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= start;
      s2_v <= s1_v;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (start) begin
      s1_led <= led_index;
      for (int i = 0; i < 3; i++) begin
        s1_prod[i] <= {7'b0, lvl[i]} * {8'b0, pct};
      end
    end
    if (s1_v) begin
      s2_led <= s1_led;
      for (int i = 0; i < 3; i++) begin
        s2_q[i] <= scaled[i][RECIP_SHIFT +: 8];
      end
    end
  end

  assign wr.en  = s2_v;
  assign wr.led = s2_led;
  assign wr.grb = {s2_q[0], s2_q[1], s2_q[2]};
  assign busy   = s1_v | s2_v;

endmodule

@@ src/rgbe_seq.sv @@
// Frame sequencer: word counters, bit store reads and the output register.
// Depends on rgbe_pkg.
module rgbe_seq
  import rgbe_pkg::*;
#(
  parameter int LED_COUNT = 4,
  parameter int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start_acc,
  input  logic              tick_acc,
  input  logic [7:0]        zero_cmp,
  input  logic [7:0]        one_cmp,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [23:0]       rd_data,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        compare_value,
  output logic              frame_last,
  output logic              sending
);

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_BITS  = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;

  localparam logic [1:0] K_IDLE  = 2'd0;
  localparam logic [1:0] K_LEAD  = 2'd1;
  localparam logic [1:0] K_BIT   = 2'd2;
  localparam logic [1:0] K_TRAIL = 2'd3;

  localparam logic [ADDR_W-1:0] LAST_LED = ADDR_W'(LED_COUNT - 1);
  localparam logic [4:0]        LAST_BIT = 5'(BITS_PER_LED - 1);

  logic              active, active_next;
  logic [1:0]        phase, phase_next;
  logic [ADDR_W-1:0] led_ctr, led_ctr_next;
  logic [4:0]        bit_ctr, bit_ctr_next;
  logic              t_v;
  logic [1:0]        t_kind, t_kind_next;
  logic [4:0]        t_bit;
  logic [4:0]        sel;
  logic [7:0]        word;

  // position update on a tick or start
  always_comb begin
    active_next  = active;
    phase_next   = phase;
    led_ctr_next = led_ctr;
    bit_ctr_next = bit_ctr;
    t_kind_next  = K_IDLE;
    if (start_acc) begin
      active_next  = 1'b1;
      phase_next   = PH_LEAD;
      led_ctr_next = '0;
      bit_ctr_next = '0;
    end else if (tick_acc && active) begin
      unique case (phase)
        PH_LEAD: begin
          t_kind_next = K_LEAD;
          phase_next  = PH_BITS;
        end
        PH_BITS: begin
          t_kind_next = K_BIT;
          if (bit_ctr == LAST_BIT) begin
            bit_ctr_next = '0;
            if (led_ctr == LAST_LED) begin
              phase_next = PH_TRAIL;
            end else begin
              led_ctr_next = led_ctr + 1'b1;
            end
          end else begin
            bit_ctr_next = bit_ctr + 1'b1;
          end
        end
        default: begin
          t_kind_next = K_TRAIL;
          active_next = 1'b0;
          phase_next  = PH_LEAD;
        end
      endcase
    end
  end

  assign rd_en   = tick_acc && active && (phase == PH_BITS);
  assign rd_addr = led_ctr;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      phase     <= PH_LEAD;
      led_ctr   <= '0;
      bit_ctr   <= '0;
      t_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      active  <= active_next;
      phase   <= phase_next;
      led_ctr <= led_ctr_next;
      bit_ctr <= bit_ctr_next;
      t_v     <= tick_acc;
      if (t_v) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // word select, MSB first within the 24-bit GRB entry
  always_comb begin
    sel  = LAST_BIT - t_bit;
    word = (t_kind == K_BIT) ? (rd_data[sel] ? one_cmp : zero_cmp) : 8'd0;
  end

  // tick payload and output register
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      t_kind <= t_kind_next;
      t_bit  <= bit_ctr;
    end
    if (t_v) begin
      compare_value <= word;
      frame_last    <= (t_kind == K_TRAIL);
      sending       <= (t_kind != K_IDLE);
    end
  end

  assign busy = t_v;

endmodule

@@ src/rgb_led_frame_encoder.sv @@
// Top level of the serial RGB LED frame encoder: config port, bit store, glue.
// Depends on rgbe_pkg, rgbe_ram, rgbe_scale, rgbe_seq and the assert header.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid / in_stall    | action, led_index, color_code, brightness
//  out     | output    | out_valid / out_stall  | compare_value, frame_last, sending
//  config  | input     | APB psel/penable/...   | zero/one bit compare registers
//
// A set transfer writes the store after two multiply stages (product, then
// reciprocal multiply); input stalls while those stages are busy.
// A tick reads the store memory (registered read) and its result is then
// captured in the output register; input stalls while the tick is in flight.
// Reset is synchronous; per-LED valid bits make unwritten entries read as zero,
// so no clearing pass follows reset. Input also stalls while a result is held.
`include "rgb_led_frame_encoder_assert.svh"

module rgb_led_frame_encoder
  import rgbe_pkg::*;
#(
  parameter int LED_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [1:0]  led_index,
  input  logic [2:0]  color_code,
  input  logic [6:0]  brightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  compare_value,
  output logic        frame_last,
  output logic        sending,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [7:0]        zero_cmp, one_cmp;
  logic              cfg_wr;
  logic              in_acc;
  logic              set_acc, start_acc, tick_acc;
  rgbe_wr_t          wr;
  logic              wr_ok;
  logic [7:0]        wr_led_ext;
  logic [ADDR_W-1:0] wr_addr;
  logic              scale_busy, seq_busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [23:0]       ram_rdata, rd_data;
  logic [LED_COUNT-1:0] led_valid;
  logic              rd_valid;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_cmp <= ZERO_CMP_RESET;
      one_cmp  <= ONE_CMP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ZERO_CMP: zero_cmp <= pwdata[7:0];
        REG_ONE_CMP:  one_cmp  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ZERO_CMP: prdata = {24'b0, zero_cmp};
      REG_ONE_CMP:  prdata = {24'b0, one_cmp};
    endcase
  end

  // input handshake and decode
  assign in_stall  = scale_busy || seq_busy || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign set_acc   = in_acc && (action == ACT_SET);
  assign start_acc = in_acc && (action == ACT_START);
  assign tick_acc  = in_acc && (action == ACT_TICK);

  rgbe_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .start      (set_acc),
    .led_index  (led_index),
    .color_code (color_code),
    .brightness (brightness),
    .wr         (wr),
    .busy       (scale_busy)
  );

  // drop writes to LEDs beyond the configured count
  assign wr_led_ext = {6'b0, wr.led};
  assign wr_ok      = wr.en && (wr_led_ext < 8'(LED_COUNT));
  assign wr_addr    = wr_led_ext[ADDR_W-1:0];

  rgbe_ram #(
    .WIDTH (24),
    .DEPTH (LED_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_addr),
    .wdata (wr.grb),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // per-LED valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_ok) begin
        led_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= led_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? ram_rdata : 24'd0;

  rgbe_seq #(
    .LED_COUNT (LED_COUNT)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start_acc     (start_acc),
    .tick_acc      (tick_acc),
    .zero_cmp      (zero_cmp),
    .one_cmp       (one_cmp),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .busy          (seq_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .compare_value (compare_value),
    .frame_last    (frame_last),
    .sending       (sending)
  );

  // checks
  `RGBE_ASSERT_NXT(a_tick_result, clk, rst, tick_acc, ##1 out_valid)
  `RGBE_ASSERT_IMP(a_last_is_zero, clk, rst, out_valid && frame_last, sending && (compare_value == '0))
  `RGBE_ASSERT_IMP(a_no_rw_overlap, clk, rst, wr_ok, !rd_en)

endmodule
